// ===== sv/cbd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbd_pkg: shared types and constants for the chunked body decoder
// Holds the beat and result structs and the default size-field width.
// ----------------------------------------------------------------------------
package cbd_pkg;

  // default width of the chunk size accumulator and the data byte counter
  localparam int SIZE_BITS_DEF = 32;

  // one input beat: a raw link byte or a link-closed marker
  typedef struct packed {
    logic [7:0] byte_in;
    logic       link_closed;
  } cbd_beat_t;

  // one result beat
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       body_done;
    logic       format_error;
  } cbd_result_t;

endpackage : cbd_pkg
`default_nettype wire

// ===== sv/cbd_in_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbd_in_reg: input register
// Captures one input beat and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module cbd_in_reg
  import cbd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire logic [7:0] byte_in,
  input  wire logic      link_closed,
  input  wire logic      advance,
  output logic           s1_valid,
  output cbd_beat_t      s1_beat
);

  logic accept;

  // stage is free when empty or when its beat moves on this cycle
  assign in_stall = s1_valid & ~advance;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_beat.byte_in     <= byte_in;
      s1_beat.link_closed <= link_closed;
    end
  end

endmodule : cbd_in_reg
`default_nettype wire

// ===== sv/cbd_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbd_core: framing state and per-byte decode
// Parses size lines, counts chunk data and flags format errors.
// ----------------------------------------------------------------------------
module cbd_core
  import cbd_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire cbd_beat_t  beat,
  output cbd_result_t     result
);

  localparam logic [1:0] PH_LINE = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  logic [1:0]           phase, phase_next;
  logic [SIZE_BITS-1:0] size_accum, size_accum_next;
  logic [SIZE_BITS-1:0] bytes_left, bytes_left_next;
  logic                 line_has_digits, line_has_digits_next;
  logic                 pending_cr, pending_cr_next;

  logic [SIZE_BITS-1:0] left_dec;
  logic                 is_hex;
  logic [3:0]           hex_val;

  // hex digit decode of the incoming byte
  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (beat.byte_in >= 8'h30 && beat.byte_in <= 8'h39) begin
      hex_val = 4'(beat.byte_in - 8'h30);
    end else if (beat.byte_in >= 8'h61 && beat.byte_in <= 8'h66) begin
      hex_val = 4'(beat.byte_in - 8'h57);
    end else if (beat.byte_in >= 8'h41 && beat.byte_in <= 8'h46) begin
      hex_val = 4'(beat.byte_in - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign left_dec = bytes_left - SIZE_BITS'(1);

  always_comb begin
    phase_next           = phase;
    size_accum_next      = size_accum;
    bytes_left_next      = bytes_left;
    line_has_digits_next = line_has_digits;
    pending_cr_next      = pending_cr;
    result               = '0;

    if (phase == PH_LINE || phase == PH_DATA) begin
      if (beat.link_closed) begin
        phase_next       = PH_DONE;
        result.body_done = 1'b1;
      end else if (phase == PH_DATA) begin
        result.payload_valid = 1'b1;
        result.payload_byte  = beat.byte_in;
        bytes_left_next      = left_dec;
        if (left_dec == '0) begin
          phase_next           = PH_LINE;
          size_accum_next      = '0;
          line_has_digits_next = 1'b0;
          pending_cr_next      = 1'b0;
        end
      end else if (pending_cr) begin
        if (beat.byte_in == CH_LF) begin
          // empty lines are skipped, a zero size ends the body
          if (line_has_digits) begin
            if (size_accum == '0) begin
              phase_next       = PH_DONE;
              result.body_done = 1'b1;
            end else begin
              phase_next      = PH_DATA;
              bytes_left_next = size_accum;
            end
          end
          size_accum_next      = '0;
          line_has_digits_next = 1'b0;
          pending_cr_next      = 1'b0;
        end else begin
          // lone cr
          phase_next          = PH_DONE;
          result.body_done    = 1'b1;
          result.format_error = 1'b1;
        end
      end else if (beat.byte_in == CH_CR) begin
        pending_cr_next = 1'b1;
      end else if (!is_hex || size_accum[SIZE_BITS-1 -: 4] != 4'd0) begin
        // bad character or size overflow
        phase_next          = PH_DONE;
        result.body_done    = 1'b1;
        result.format_error = 1'b1;
      end else begin
        size_accum_next      = {size_accum[SIZE_BITS-5:0], hex_val};
        line_has_digits_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LINE;
      size_accum      <= '0;
      bytes_left      <= '0;
      line_has_digits <= 1'b0;
      pending_cr      <= 1'b0;
    end else if (fire) begin
      phase           <= phase_next;
      size_accum      <= size_accum_next;
      bytes_left      <= bytes_left_next;
      line_has_digits <= line_has_digits_next;
      pending_cr      <= pending_cr_next;
    end
  end

endmodule : cbd_core
`default_nettype wire

// ===== sv/cbd_out_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbd_out_reg: result register
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module cbd_out_reg
  import cbd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s1_valid,
  input  wire cbd_result_t result,
  output logic             advance,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             payload_valid,
  output logic [7:0]       payload_byte,
  output logic             body_done,
  output logic             format_error
);

  cbd_result_t held;

  // register can load when empty or when its beat is taken now
  assign advance = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      held <= result;
    end
  end

  assign payload_valid = held.payload_valid;
  assign payload_byte  = held.payload_byte;
  assign body_done     = held.body_done;
  assign format_error  = held.format_error;

endmodule : cbd_out_reg
`default_nettype wire

// ===== sv/chunked_body_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chunked_body_decoder: http chunked transfer decoder
// Strips chunk-size lines and framing crlf from a byte stream and passes
// the body bytes out, one result beat per input beat.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | fields
//   --------+----------------------+---------------------------------------
//   input   | in_valid / in_stall  | byte_in, link_closed
//   output  | out_valid / out_stall| payload_valid, payload_byte,
//           |                      | body_done, format_error
//
// every input beat gives exactly one result beat; one beat per cycle is
// sustained while out_stall is low, through the input register and the result
// register, with the single decode step between them
// reset (rst, synchronous) empties both registers and returns the parser to
// the size-line phase
// a stalled output holds its beat; the input register keeps taking beats as
// long as the result register can load, so in_stall rises only when both
// stages are full
// after the body ends (zero chunk, format error, link close) every further
// beat yields an all-zero result
// ----------------------------------------------------------------------------
module chunked_body_decoder
  import cbd_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] byte_in,
  input  wire logic       link_closed,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            payload_valid,
  output logic [7:0]      payload_byte,
  output logic            body_done,
  output logic            format_error
);

  logic        advance;   // result register can load this cycle
  logic        s1_valid;  // input register holds a beat
  logic        fire;      // beat in input register is decoded and moved on
  cbd_beat_t   s1_beat;
  cbd_result_t result;

  assign fire = s1_valid & advance;

  // input register
  cbd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_in    (byte_in),
    .link_closed(link_closed),
    .advance    (advance),
    .s1_valid   (s1_valid),
    .s1_beat    (s1_beat)
  );

  // framing state machine and byte decode
  cbd_core #(
    .SIZE_BITS(SIZE_BITS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .beat  (s1_beat),
    .result(result)
  );

  // result register
  cbd_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .s1_valid     (s1_valid),
    .result       (result),
    .advance      (advance),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .payload_valid(payload_valid),
    .payload_byte (payload_byte),
    .body_done    (body_done),
    .format_error (format_error)
  );

endmodule : chunked_body_decoder
`default_nettype wire
